[hw/rtl/hsp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the Q15 product for the harmonic surface point block.
// No dependencies.
package hsp_pkg;

    typedef logic signed [18:0] q_t;

    localparam int NUM_REGS = 8;
    localparam int NUM_LANES = 8;
    localparam int POW_STAGES = 6;
    localparam int CFG_W = 3;

    localparam q_t ONE_Q15 = 19'sd32768;
    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [15:0] SIN_B = 16'd42048;
    localparam logic [12:0] SIN_C = 13'd4640;
    localparam logic [CFG_W-1:0] POW_ZERO = 3'd7;

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] =
        '{3'd0, 3'd4, 3'd0, 3'd3, 3'd2, 3'd2, 3'd4, 3'd1};

    // Rounded product of two Q15 values, formed on magnitudes.
    function automatic q_t mul_q15(input q_t a, input q_t b);
        logic [18:0] ma;
        logic [18:0] mb;
        logic [37:0] pr;
        logic [22:0] m;
        logic        neg;
        begin
            neg = a[18] ^ b[18];
            ma  = a[18] ? 19'(-a) : 19'(a);
            mb  = b[18] ? 19'(-b) : 19'(b);
            pr  = ma * mb + 38'd16384;
            m   = pr[37:15];
            mul_q15 = neg ? -q_t'(m[18:0]) : q_t'(m[18:0]);
        end
    endfunction

endpackage

[hw/rtl/hsp_if.sv]
`timescale 1ns / 1ps
// Handshake channels for the harmonic surface point block: angle items in, points out.
// No dependencies.
interface hsp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] theta;
    logic [15:0] phi;
    logic [31:0] time_tick;
    modport source (output valid, theta, phi, time_tick, input ready);
    modport sink (input valid, theta, phi, time_tick, output ready);
endinterface

interface hsp_out_if;
    logic               valid;
    logic               ready;
    logic signed [18:0] pos_x;
    logic signed [18:0] pos_y;
    logic signed [18:0] pos_z;
    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

[hw/rtl/harmonic_surface_point_top.sv]
`timescale 1ns / 1ps
// Top level of the harmonic surface point block: phases, sines, powers and projection.
// Depends on hsp_pkg and the channels in hsp_if.
//
//  channel   direction  contents
//  pt_in     sink       theta, phi, time_tick
//  pt_out    source     pos_x, pos_y, pos_z
//  cfg       write      cfg_we, cfg_index, cfg_data
//
// One item enters per cycle unless the output register is full and not being taken.
// The pipeline runs through the phase register, four sine multiplies, six power steps,
// the radius sum and two projection products.
// All stages advance together whenever the output register is empty or being taken.
// Reset clears the valid bits and restores the register defaults.
module harmonic_surface_point_top
    import hsp_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    hsp_in_if.sink           pt_in,
    hsp_out_if.source        pt_out
);

    localparam int AB = ANGLE_BITS;
    localparam int NST = 14;
    localparam logic [63:0] DEN = 64'd100 << 32;
    localparam logic [63:0] HALF = 64'd50 << 32;
    localparam logic [AB-1:0] RATE1 = AB'((((64'd1 * 64'd683565276) << AB) + HALF) / DEN);
    localparam logic [AB-1:0] RATE2 = AB'((((64'd2 * 64'd683565276) << AB) + HALF) / DEN);
    localparam logic [AB-1:0] RATE3 = AB'((((64'd3 * 64'd683565276) << AB) + HALF) / DEN);
    localparam logic [AB-1:0] RATE4 = AB'((((64'd4 * 64'd683565276) << AB) + HALF) / DEN);
    localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

    logic [CFG_W-1:0] cfg_reg [NUM_REGS];
    logic [NST-1:0]   v_reg;
    logic             en;

    logic [AB-1:0] th_w;
    logic [AB-1:0] ph_w;
    logic [AB-1:0] phase_next [NUM_LANES];
    logic [AB-1:0] phase_reg [NUM_LANES];

    logic [22:0] z1_reg [NUM_LANES];
    logic [22:0] zz1_reg [NUM_LANES];
    logic [1:0]  q1_reg [NUM_LANES];
    logic [22:0] z1_next [NUM_LANES];
    logic [22:0] zz1_next [NUM_LANES];
    logic [1:0]  q1_next [NUM_LANES];

    logic [22:0] z2_reg [NUM_LANES];
    logic [22:0] zz2_reg [NUM_LANES];
    logic [1:0]  q2_reg [NUM_LANES];
    logic [15:0] u2_reg [NUM_LANES];
    logic [15:0] u2_next [NUM_LANES];

    logic [22:0] z3_reg [NUM_LANES];
    logic [1:0]  q3_reg [NUM_LANES];
    logic [16:0] w3_reg [NUM_LANES];
    logic [16:0] w3_next [NUM_LANES];

    q_t sn4_reg [NUM_LANES];
    q_t sn4_next [NUM_LANES];

    q_t acc_reg [POW_STAGES][4];
    q_t base_reg [POW_STAGES][4];
    q_t trig_reg [POW_STAGES][4];
    q_t acc_next [POW_STAGES][4];

    q_t r_reg, r_next;
    q_t tr11_reg [4];
    q_t rs_reg, ry_reg;
    q_t sth12_reg, cth12_reg;
    q_t x_reg, y_reg, zo_reg;

    assign en = !v_reg[NST-1] || pt_out.ready;
    assign pt_in.ready = en;

    generate
        if (AB >= 16)
        begin : g_wide
            assign th_w = AB'(pt_in.theta) << (AB - 16);
            assign ph_w = AB'(pt_in.phi) << (AB - 16);
        end
        else
        begin : g_narrow
            assign th_w = AB'(pt_in.theta >> (16 - AB));
            assign ph_w = AB'(pt_in.phi >> (16 - AB));
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], pt_in.valid};
        end
    end

    // Phases: lanes hold a, b, c, d, then sin and cos of phi and of theta.
    always_comb
    begin
        logic [AB-1:0] tk;
        tk = pt_in.time_tick[AB-1:0];
        phase_next[0] = AB'(cfg_reg[0] * ph_w) + AB'(tk * RATE1);
        phase_next[1] = AB'(cfg_reg[2] * ph_w) + AB'(tk * RATE2) + QUARTER;
        phase_next[2] = AB'(cfg_reg[4] * th_w) + AB'(tk * RATE3);
        phase_next[3] = AB'(cfg_reg[6] * th_w) + AB'(tk * RATE4) + QUARTER;
        phase_next[4] = ph_w;
        phase_next[5] = ph_w + QUARTER;
        phase_next[6] = th_w;
        phase_next[7] = th_w + QUARTER;
    end

    always_comb
    begin
        logic [23:0] p;
        logic [45:0] zz;
        logic [35:0] tp;
        logic [38:0] vp;
        logic [39:0] sp;
        logic [18:0] m;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            p = 24'(phase_reg[i]) << (24 - AB);
            q1_next[i] = p[23:22];
            z1_next[i] = p[22] ? (23'd4194304 - {1'b0, p[21:0]}) : {1'b0, p[21:0]};
            zz = z1_next[i] * z1_next[i];
            zz1_next[i] = zz[44:22];
            tp = SIN_C * zz1_reg[i];
            u2_next[i] = SIN_B - 16'(tp[35:22]);
            vp = u2_reg[i] * zz2_reg[i];
            w3_next[i] = SIN_A - vp[38:22];
            sp = w3_reg[i] * z3_reg[i];
            m = (19'(sp[39:22]) + 19'd1) >> 1;
            sn4_next[i] = q3_reg[i][1] ? -q_t'(m) : q_t'(m);
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            acc_next[0][j] = (cfg_reg[2*j+1] > 3'd0) ?
                mul_q15(ONE_Q15, sn4_reg[j]) : ONE_Q15;
            for (int k = 1; k < POW_STAGES; k++)
            begin
                acc_next[k][j] = (cfg_reg[2*j+1] > 3'(k)) ?
                    mul_q15(acc_reg[k-1][j], base_reg[k-1][j]) : acc_reg[k-1][j];
            end
        end
    end

    always_comb
    begin
        r_next = '0;
        for (int j = 0; j < 4; j++)
        begin
            if (cfg_reg[2*j+1] != POW_ZERO)
            begin
                r_next = r_next + acc_reg[POW_STAGES-1][j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                phase_reg[i] <= phase_next[i];
                z1_reg[i]    <= z1_next[i];
                zz1_reg[i]   <= zz1_next[i];
                q1_reg[i]    <= q1_next[i];
                z2_reg[i]    <= z1_reg[i];
                zz2_reg[i]   <= zz1_reg[i];
                q2_reg[i]    <= q1_reg[i];
                u2_reg[i]    <= u2_next[i];
                z3_reg[i]    <= z2_reg[i];
                q3_reg[i]    <= q2_reg[i];
                w3_reg[i]    <= w3_next[i];
                sn4_reg[i]   <= sn4_next[i];
            end
            for (int j = 0; j < 4; j++)
            begin
                acc_reg[0][j]  <= acc_next[0][j];
                base_reg[0][j] <= sn4_reg[j];
                trig_reg[0][j] <= sn4_reg[j+4];
                for (int k = 1; k < POW_STAGES; k++)
                begin
                    acc_reg[k][j]  <= acc_next[k][j];
                    base_reg[k][j] <= base_reg[k-1][j];
                    trig_reg[k][j] <= trig_reg[k-1][j];
                end
            end
            r_reg <= r_next;
            for (int j = 0; j < 4; j++)
            begin
                tr11_reg[j] <= trig_reg[POW_STAGES-1][j];
            end
            rs_reg    <= mul_q15(r_reg, tr11_reg[0]);
            ry_reg    <= mul_q15(r_reg, tr11_reg[1]);
            sth12_reg <= tr11_reg[2];
            cth12_reg <= tr11_reg[3];
            x_reg     <= mul_q15(rs_reg, cth12_reg);
            y_reg     <= ry_reg;
            zo_reg    <= mul_q15(rs_reg, sth12_reg);
        end
    end

    assign pt_out.valid = v_reg[NST-1];
    assign pt_out.pos_x = x_reg;
    assign pt_out.pos_y = y_reg;
    assign pt_out.pos_z = zo_reg;

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        pt_in.valid && pt_in.ready |=> v_reg[0])
        else $error("accepted item did not enter the pipeline");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("valid bits moved during a stall");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        pt_out.valid |-> (y_reg <= 19'sd131072) && (y_reg >= -19'sd131072))
        else $error("pos_y outside Q3.15 range");

endmodule
